@@ rtl/core/bm3_pkg.sv @@
// Shared types and constants for the 3x3 binary morphology core.
`timescale 1ns / 1ps
package bm3_pkg;

  localparam int BM3_MAX_WIDTH  = 1024;
  localparam int BM3_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = CFG_DATA_W'(1024);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FILTER_MODE  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_DILATE = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  // What the back end does with one queued request.
  typedef enum logic {
    CMD_PIXEL = 1'b0,  // push a pixel into the first stage
    CMD_FLUSH = 1'b1   // push a zero filler into the second stage
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      pixel;
  } cmd_t;

endpackage

@@ rtl/core/bm3_queue.sv @@
// Two-entry queue used between the front and back ends and on the result side.
`timescale 1ns / 1ps
module bm3_queue #(
  parameter int WIDTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue occupancy beyond two entries");

endmodule

@@ rtl/core/bm3_front.sv @@
// Front end: accepts pixels, drops in-frame padding, classifies requests for the back end.
`timescale 1ns / 1ps
module bm3_front import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = BM3_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM3_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_restart,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]   w,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  h,
  input  logic                               two,
  input  logic                               in_push,
  input  logic                               in_pixel,
  input  logic                               in_padding,
  output logic                               in_full,
  output logic                               cmd_push,
  output cmd_t                               cmd,
  input  logic                               cmd_full
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [WW-1:0] fill_r, fill_nxt;
  logic          accept;
  logic          in_frame;
  logic          s1_busy;
  logic          s1_end;
  logic          col_wrap;
  logic          frame_end;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    in_frame  = 32'(row_r) < 32'(h);
    s1_end    = (32'(row_r) == 32'(h) + 32'd1) && (col_r == '0);
    s1_busy   = (32'(row_r) <= 32'(h)) || s1_end;
    col_wrap  = (32'(col_r) + 32'd1) >= 32'(w);
    row_nxt   = row_r;
    col_nxt   = col_r;
    fill_nxt  = fill_r;
    cmd_push  = 1'b0;
    cmd.kind  = CMD_PIXEL;
    cmd.pixel = 1'b0;
    frame_end = 1'b0;
    if (accept) begin
      if (in_frame && in_padding) begin
        // drop: padding before the frame is complete changes nothing
      end else if (s1_busy) begin
        cmd_push  = 1'b1;
        cmd.pixel = in_frame && in_pixel;
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + AW'(1);
        end
        if (!two && s1_end) begin
          frame_end = 1'b1;
        end
      end else if (two) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_FLUSH;
        if (32'(fill_r) == 32'(w)) begin
          frame_end = 1'b1;
        end else begin
          fill_nxt = fill_r + WW'(1);
        end
      end else begin
        frame_end = 1'b1;
      end
    end
    if (frame_end || cfg_restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      fill_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ rtl/core/bm3_stage.sv @@
// One 3x3 min/max stage: two-row line store, sliding window and border masks.
`timescale 1ns / 1ps
module bm3_stage import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = BM3_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM3_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic                               push,
  input  logic                               pix,
  input  logic                               dilate,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]   w,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  h,
  output logic                               res_valid,
  output logic                               res,
  output logic                               res_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [1:0]    line_mem [MAX_WIDTH];
  logic [1:0]    rd_r;
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [8:0]    win_r, win_nxt;
  logic [AW-1:0] rd_addr;
  logic [2:0]    new_col;
  logic [1:0]    wr_data;
  logic [8:0]    nb;
  logic          col_wrap;
  logic          in_range;
  logic [RW-1:0] qr;
  logic [AW-1:0] qc;
  logic [2:0]    row_ok;
  logic [2:0]    col_ok;
  logic          acc;

  // Line store entry: bit 0 is the row above, bit 1 the row two above.
  assign new_col = {pix, rd_r[0], rd_r[1]};
  assign wr_data = {rd_r[0], pix};
  assign nb      = {new_col, win_r[8:3]};

  always_comb begin
    col_wrap = (32'(col_r) + 32'd1) >= 32'(w);
    rd_addr  = col_wrap ? '0 : col_r + AW'(1);
    in_range = ((32'(row_r) >= 32'd2) || ((32'(row_r) == 32'd1) && (col_r != '0))) &&
               ((32'(row_r) <= 32'(h)) ||
                ((32'(row_r) == 32'(h) + 32'd1) && (col_r == '0)));
    // Window center sits one row and one column behind the incoming pixel.
    if (col_r != '0) begin
      qr = row_r - RW'(1);
      qc = col_r - AW'(1);
    end else begin
      qr = row_r - RW'(2);
      qc = AW'(32'(w) - 32'd1);
    end
    row_ok = {(32'(qr) + 32'd1) < 32'(h), 1'b1, qr != '0};
    col_ok = {(32'(qc) + 32'd1) < 32'(w), 1'b1, qc != '0};
    acc = !dilate;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        if (!(dr == 1 && dc == 1) && row_ok[dr] && col_ok[dc]) begin
          if (dilate) begin
            acc = acc | nb[dc * 3 + dr];
          end else begin
            acc = acc & nb[dc * 3 + dr];
          end
        end
      end
    end
    res_valid = push && in_range;
    res       = acc;
    res_last  = res_valid && ((32'(qr) + 32'd1) == 32'(h)) &&
                ((32'(qc) + 32'd1) == 32'(w));

    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    if (push) begin
      win_nxt = nb;
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      win_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= win_nxt;
    end
  end

  // Write this column, prefetch the next one; bypass when both are the same entry.
  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[col_r] <= wr_data;
      if (rd_addr == col_r) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= line_mem[rd_addr];
      end
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (row_r == '0 && col_r == '0 && win_r == '0))
    else $error("stage position not cleared after restart");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w))
    else $error("stage column beyond image width");

endmodule

@@ rtl/core/bm3_back.sv @@
// Back end: runs requests through one or two morphology stages and emits results.
`timescale 1ns / 1ps
module bm3_back import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = BM3_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM3_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_restart,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]   w,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  h,
  input  mode_t                              mode,
  input  logic                               cmd_empty,
  input  cmd_t                               cmd,
  output logic                               cmd_pop,
  input  logic                               out_full,
  output logic                               out_push,
  output logic                               out_pixel,
  output logic                               out_last
);

  logic advance;
  logic two;
  logic s1_dilate, s2_dilate;
  logic s1_push, s2_push;
  logic s2_pix;
  logic s1_valid, s1_res, s1_last;
  logic s2_valid, s2_res, s2_last;
  logic restart;

  always_comb begin
    // Hold the request until there is room for its result.
    advance   = !cmd_empty && !out_full;
    two       = mode inside {MODE_OPEN, MODE_CLOSE};
    s1_dilate = mode inside {MODE_DILATE, MODE_CLOSE};
    s2_dilate = (mode == MODE_OPEN);
    s1_push   = advance && (cmd.kind == CMD_PIXEL);
    s2_pix    = (cmd.kind == CMD_PIXEL) ? s1_res : 1'b0;
    s2_push   = advance && two && ((cmd.kind == CMD_FLUSH) || s1_valid);
    out_push  = two ? s2_valid : s1_valid;
    out_pixel = two ? s2_res : s1_res;
    out_last  = two ? s2_last : s1_last;
    restart   = cfg_restart || (out_push && out_last);
  end

  assign cmd_pop = advance;

  bm3_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .push      (s1_push),
    .pix       (cmd.pixel),
    .dilate    (s1_dilate),
    .w         (w),
    .h         (h),
    .res_valid (s1_valid),
    .res       (s1_res),
    .res_last  (s1_last)
  );

  bm3_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .push      (s2_push),
    .pix       (s2_pix),
    .dilate    (s2_dilate),
    .w         (w),
    .h         (h),
    .res_valid (s2_valid),
    .res       (s2_res),
    .res_last  (s2_last)
  );

  a_single_stage_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !two |-> !s2_push)
    else $error("second stage advanced in a single-stage mode");

endmodule

@@ rtl/core/binary_morphology_3x3_core.sv @@
// Top level of the streaming 3x3 binary dilation / erosion / opening / closing core.
`timescale 1ns / 1ps
// Takes one binary pixel per clock in raster order and returns the filtered image in raster
// order, also one pixel per clock unless a queue is full; the rate is set by each stage's
// line store read-modify-write (prefetched one column ahead). A result for pixel q leaves
// with the item that brings pixel q+width+1 (dilation, erosion) or q+2*(width+1) (opening,
// closing), then crosses the request and result queues. After the last pixel of a frame,
// send width+1 (one stage) or 2*(width+1) (two stages) padding items to push out the tail;
// out_frame_last marks the final pixel and the next input item starts a new frame. Padding
// items arriving before the frame is complete are dropped. Line stores need no clearing pass
// after reset. Any register write restarts the frame; write only while the core is idle.
module binary_morphology_3x3_core import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = BM3_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM3_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_pixel_in,
  input  logic                   in_padding,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_pixel_out,
  output logic                   out_frame_last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  mode_t                 mode_r;
  logic                  cfg_hit;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic                  two;

  logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t                  cmd_in, cmd_out;
  logic                  res_push, res_full, res_pixel, res_last;
  logic [1:0]            res_rdata;

  always_comb begin
    cfg_hit = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT) ||
                         (cfg_index == REG_FILTER_MODE));
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
    two = mode_r inside {MODE_OPEN, MODE_CLOSE};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
      mode_r   <= MODE_DILATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        REG_FILTER_MODE:  mode_r   <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  bm3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_restart (cfg_hit),
    .w           (w_eff),
    .h           (h_eff),
    .two         (two),
    .in_push     (in_push),
    .in_pixel    (in_pixel_in),
    .in_padding  (in_padding),
    .in_full     (in_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  bm3_queue #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  bm3_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_restart (cfg_hit),
    .w           (w_eff),
    .h           (h_eff),
    .mode        (mode_r),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .out_full    (res_full),
    .out_push    (res_push),
    .out_pixel   (res_pixel),
    .out_last    (res_last)
  );

  bm3_queue #(
    .WIDTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_pixel, res_last}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_pixel_out  = res_rdata[1];
  assign out_frame_last = res_rdata[0];

endmodule

@@ test/binary_morphology_3x3_checker.sv @@
// Checker for the 3x3 morphology core: predicts every filtered pixel and compares results.
`timescale 1ns / 1ps
module binary_morphology_3x3_checker import bm3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  logic                   in_pixel_in,
  input  logic                   in_padding,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  logic                   out_pixel_out,
  input  logic                   out_frame_last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } morph_result_t;

  morph_result_t pending_pixels[$];

  // Per stage: two rows of history per column, a 3x3 window and position counters.
  bit [1:0] line_store [2][BM3_MAX_WIDTH];
  bit [8:0] window [2];
  int       row_cnt [2];
  int       col_cnt [2];
  int       out_count;

  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  mode_t                 mode_reg;

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int s = 0; s < 2; s++) begin
      window[s]  = '0;
      row_cnt[s] = 0;
      col_cnt[s] = 0;
    end
    out_count = 0;
  endfunction

  // Push one value into stage s; returns 1 when the stage yields a filtered pixel.
  function automatic bit window_push(int s, bit v, bit dilate, int w, int h, output bit res);
    int       col;
    int       pos;
    bit       valid;
    bit [2:0] newcol;
    int       cc;
    int       qr;
    int       qc;
    int       rr;
    int       cx;
    int       ci;
    bit       acc;
    col    = col_cnt[s];
    pos    = row_cnt[s] * w + col;
    valid  = (pos >= w + 1) && (pos - (w + 1) < w * h);
    newcol = {v, line_store[s][col][0], line_store[s][col][1]};
    line_store[s][col] = {line_store[s][col][0], v};
    if (col != 0) begin
      window[s] = {newcol, window[s][8:3]};
      cc = 1;
      qr = row_cnt[s] - 1;
      qc = col - 1;
    end else begin
      // row wrap: the window still holds the last columns of the row above
      cc = 2;
      qr = row_cnt[s] - 2;
      qc = w - 1;
    end
    res = 1'b0;
    if (valid) begin
      acc = !dilate;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          rr = qr + dr - 1;
          cx = qc + dc - 1;
          ci = cc + dc;
          if (dr == 1 && dc == 1) continue;
          if (rr < 0 || rr >= h) continue;
          if (cx < 0 || cx >= w) continue;
          if (ci > 3) continue;
          if (dilate) acc = acc | window[s][(ci - 1) * 3 + dr];
          else acc = acc & window[s][(ci - 1) * 3 + dr];
        end
      end
      res = acc;
    end
    if (col == 0) window[s] = {newcol, window[s][8:3]};
    col_cnt[s]++;
    if (col_cnt[s] >= w) begin
      col_cnt[s] = 0;
      row_cnt[s]++;
    end
    return valid;
  endfunction

  function automatic void morph_step(bit pix, bit pad);
    int w;
    int h;
    int total;
    int p1;
    bit two;
    bit first_dilate;
    bit v;
    bit mid;
    bit res;
    bit have;
    w            = clamp_size(int'(width_reg), BM3_MAX_WIDTH);
    h            = clamp_size(int'(height_reg), BM3_MAX_HEIGHT);
    total        = w * h;
    two          = (mode_reg == MODE_OPEN) || (mode_reg == MODE_CLOSE);
    first_dilate = (mode_reg == MODE_DILATE) || (mode_reg == MODE_CLOSE);
    p1           = row_cnt[0] * w + col_cnt[0];
    v            = pix;
    mid          = 1'b0;
    res          = 1'b0;
    have         = 1'b0;
    if (p1 < total) begin
      // drop padding inside the frame
      if (pad) return;
    end else begin
      v = 1'b0;
    end
    if (p1 < total + w + 1) begin
      if (window_push(0, v, first_dilate, w, h, mid)) begin
        if (two) begin
          have = window_push(1, mid, mode_reg == MODE_OPEN, w, h, res);
        end else begin
          have = 1'b1;
          res  = mid;
        end
      end
    end else if (two) begin
      have = window_push(1, 1'b0, mode_reg == MODE_OPEN, w, h, res);
    end else begin
      restart_frame();
      return;
    end
    if (!have) return;
    out_count++;
    pending_pixels.push_back('{pixel_out: res, frame_last: (out_count >= total)});
    if (out_count >= total) restart_frame();
  endfunction

  function automatic void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data;
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data;
        restart_frame();
      end
      REG_FILTER_MODE: begin
        mode_reg = mode_t'(data[1:0]);
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    morph_result_t want;
    if (!rst_n) begin
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      mode_reg   = MODE_DILATE;
      restart_frame();
      pending_pixels.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $error("unexpected result: pixel_out %0b, frame_last %0b",
                 out_pixel_out, out_frame_last);
        end else begin
          want = pending_pixels.pop_front();
          if (out_pixel_out !== want.pixel_out) begin
            errors++;
            $error("pixel_out mismatch: expected %0b, actual %0b", want.pixel_out, out_pixel_out);
          end
          if (out_frame_last !== want.frame_last) begin
            errors++;
            $error("frame_last mismatch: expected %0b, actual %0b",
                   want.frame_last, out_frame_last);
          end
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_push && !in_full) morph_step(in_pixel_in, in_padding);
    end
    pending = pending_pixels.size();
  end

endmodule

@@ test/binary_morphology_3x3_core_tb.sv @@
// Testbench top for the 3x3 morphology core: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module binary_morphology_3x3_core_tb;
  import bm3_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 16;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_push     = 1'b0;
  logic                   in_pixel_in = 1'b0;
  logic                   in_padding  = 1'b0;
  logic                   out_pop     = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
  wire                    in_full;
  wire                    out_empty;
  wire                    out_pixel_out;
  wire                    out_frame_last;
  int                     errors;
  int                     pending;

  int       cycles;
  int       item_count;
  int       burst_left;
  bit       steady;
  bit [6:0] stall_cnt;
  bit [1:0] stall_style;
  bit [7:0] stall_pat;
  int       pop_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  binary_morphology_3x3_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_in    (in_pixel_in),
    .in_padding     (in_padding),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  binary_morphology_3x3_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_in    (in_pixel_in),
    .in_padding     (in_padding),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: switch stall style each time the 7-bit stall counter wraps.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 7'd1;
    if (stall_cnt == 7'd0) begin
      stall_style <= 2'($urandom_range(0, 2));
      stall_pat   <= 8'($urandom) | 8'h01;
      pop_pct     <= $urandom_range(20, 90);
    end
    case (stall_style)
      2'd0:    out_pop <= 1'b1;
      2'd1:    out_pop <= ($urandom_range(0, 99) < pop_pct);
      default: out_pop <= stall_pat[stall_cnt[2:0]];
    endcase
  end

  task automatic send_item(bit pix, bit pad);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) gap = $urandom_range(0, 6);
    end
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push     <= 1'b1;
    in_pixel_in <= pix;
    in_padding  <= pad;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic configure(int w_raw, int h_raw, mode_t m);
    write_reg(REG_IMAGE_WIDTH, w_raw);
    write_reg(REG_IMAGE_HEIGHT, h_raw);
    write_reg(REG_FILTER_MODE, int'(m));
    cfg_we <= 1'b0;
  endtask

  // Hold off until every expected pixel is out, then let the pipeline empty.
  task automatic settle();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cut != 0 abandons the frame after that many counted items.
  task automatic run_frame(int w, int h, bit two, int density, int pad_pct, int cut);
    int total;
    int flush;
    total = w * h;
    flush = two ? 2 * (w + 1) : w + 1;
    for (int i = 0; i < total + flush; i++) begin
      if (cut != 0 && i >= cut) break;
      if (i < total) begin
        while ($urandom_range(0, 99) < pad_pct) send_item($urandom_range(0, 1), 1'b1);
        send_item($urandom_range(0, 99) < density, 1'b0);
      end else begin
        // after the last pixel every item is a filler, padding bit or not
        send_item($urandom_range(0, 1), $urandom_range(0, 1));
      end
      item_count++;
    end
  endtask

  task automatic run_phase(int w_raw, int h_raw, mode_t m, int frames, int density,
                           int pad_pct, bit abandon);
    int  w;
    int  h;
    bit  two;
    int  cut;
    w   = (w_raw < 1) ? 1 : ((w_raw > BM3_MAX_WIDTH) ? BM3_MAX_WIDTH : w_raw);
    h   = (h_raw < 1) ? 1 : ((h_raw > BM3_MAX_HEIGHT) ? BM3_MAX_HEIGHT : h_raw);
    two = (m == MODE_OPEN) || (m == MODE_CLOSE);
    configure(w_raw, h_raw, m);
    steady = ($urandom_range(0, 3) == 0);
    for (int f = 0; f < frames; f++) begin
      cut = 0;
      if (abandon && f == frames - 1)
        cut = $urandom_range(1, w * h + (two ? 2 : 1) * (w + 1) - 1);
      run_frame(w, h, two, density, pad_pct, cut);
    end
    settle();
  endtask

  initial begin
    int w_raw;
    int h_raw;
    int sel;
    int density;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few pixels under the reset sizes; the first register write abandons them
    steady = 1'b1;
    repeat (3) send_item($urandom_range(0, 1), 1'b0);
    settle();

    // single pixel: no neighbors inside the image
    run_phase(1, 1, MODE_DILATE, 1, 100, 0, 1'b0);
    run_phase(1, 1, MODE_ERODE, 1, 0, 0, 1'b0);

    // write to the unused index must not disturb the frame
    configure(3, 2, MODE_OPEN);
    write_reg(REG_SPARE, 2047);
    cfg_we <= 1'b0;
    run_frame(3, 2, 1'b1, 50, 20, 0);
    settle();

    // size extremes, out-of-range values clamp; long frames are cut short
    configure(2047, 0, MODE_ERODE);
    run_frame(1024, 1, 1'b0, 50, 0, 1080);
    settle();
    configure(0, 2047, MODE_CLOSE);
    run_frame(1, 1024, 1'b1, 30, 5, 40);
    settle();

    // random phases until the item budget is spent
    while (item_count < RANDOM_ITEMS) begin
      sel   = $urandom_range(0, 9);
      w_raw = (sel == 0) ? 0 : ((sel == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12));
      sel   = $urandom_range(0, 9);
      h_raw = (sel == 0) ? 0 : ((sel == 1) ? $urandom_range(9, 20) : $urandom_range(1, 8));
      sel   = $urandom_range(0, 4);
      density = (sel == 0) ? 0 : ((sel == 1) ? 100 : $urandom_range(10, 90));
      run_phase(w_raw, h_raw, mode_t'($urandom_range(0, 3)), $urandom_range(1, 3), density,
                ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 30),
                $urandom_range(0, 7) == 0);
    end

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bm3_pkg.sv
rtl/core/bm3_queue.sv
rtl/core/bm3_front.sv
rtl/core/bm3_stage.sv
rtl/core/bm3_back.sv
rtl/core/binary_morphology_3x3_core.sv
test/binary_morphology_3x3_checker.sv
test/binary_morphology_3x3_core_tb.sv
